FILE: design/fie_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// fie_pkg
// Shared types and constants for the three-input fuzzy inference pipeline.
// -----------------------------------------------------------------------------
package fie_pkg;

  localparam int INPUT_COUNT = 3;
  localparam int COMBOS      = 1 << INPUT_COUNT;
  localparam int MEMB_W      = 17;
  localparam logic [MEMB_W-1:0] MEMB_ONE = 17'h10000;
  localparam int LANE_LAT    = 20;
  localparam int RDIV_STAGES = 17;
  localparam int QDIV_STAGES = 16;
  localparam int MERGE_LAT   = QDIV_STAGES + 5;
  localparam int IDX_W       = 4;

  typedef logic [MEMB_W-1:0] memb_t;
  typedef memb_t memb_arr_t [INPUT_COUNT];
  typedef logic signed [15:0] cons_arr_t [COMBOS];

  // Segment of the S-curve that an input falls in
  typedef enum logic [1:0] {
    SEG_ZERO = 2'd0,
    SEG_ONE  = 2'd1,
    SEG_RISE = 2'd2,
    SEG_FALL = 2'd3
  } seg_t;

endpackage
`default_nettype wire

FILE: design/fie_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// fie_lane
// Membership of one input: segment select, pipelined ratio divider (one
// quotient bit per stage), then two squaring stages.
// -----------------------------------------------------------------------------
module fie_lane (
  input  wire logic               clk,
  input  wire logic signed [15:0] x,
  input  wire logic [14:0]        knee,
  output fie_pkg::memb_t          memb
);
  import fie_pkg::*;

  seg_t        s0_seg;
  logic [14:0] s0_d;
  logic [14:0] s0_k;

  seg_t        div_seg  [RDIV_STAGES];
  logic [14:0] div_k    [RDIV_STAGES];
  logic [14:0] div_rem  [RDIV_STAGES];
  logic [16:0] div_quot [RDIV_STAGES];

  seg_t        sq_seg;
  logic [16:0] r2;
  logic [33:0] r_sq;
  logic [33:0] r2_sq;
  logic [15:0] half_r4;

  logic [16:0] two_k;
  logic [16:0] x_pos;
  seg_t        seg_c;
  logic [14:0] d_c;

  // Classify the input against the knee
  assign two_k = {1'b0, knee, 1'b0};
  assign x_pos = {2'b00, x[14:0]};
  always_comb begin
    d_c = x[14:0];
    if (x[15] || x == 16'sd0) begin
      seg_c = SEG_ZERO;
    end else if (knee == 15'd0 || x_pos > two_k) begin
      seg_c = SEG_ONE;
    end else if (x[14:0] <= knee) begin
      seg_c = SEG_RISE;
    end else begin
      seg_c = SEG_FALL;
      d_c   = 15'(two_k - x_pos);
    end
  end

  always_ff @(posedge clk) begin
    s0_seg <= seg_c;
    s0_d   <= d_c;
    s0_k   <= knee;
  end

  // Restoring divider for d * 2^16 / k, one quotient bit per stage
  for (genvar j = 0; j < RDIV_STAGES; j++) begin : g_div
    logic [15:0] trial;
    logic        ge;
    seg_t        seg_in;
    logic [14:0] k_in;
    logic [16:0] quot_in;
    if (j == 0) begin : g_first
      assign trial   = {1'b0, s0_d};
      assign seg_in  = s0_seg;
      assign k_in    = s0_k;
      assign quot_in = '0;
    end else begin : g_rest
      assign trial   = {div_rem[j-1], 1'b0};
      assign seg_in  = div_seg[j-1];
      assign k_in    = div_k[j-1];
      assign quot_in = div_quot[j-1];
    end
    assign ge = trial >= {1'b0, k_in};
    always_ff @(posedge clk) begin
      div_seg[j]  <= seg_in;
      div_k[j]    <= k_in;
      div_rem[j]  <= ge ? 15'(trial - {1'b0, k_in}) : trial[14:0];
      div_quot[j] <= {quot_in[15:0], ge};
    end
  end

  // Square the ratio, then square again
  assign r_sq  = div_quot[RDIV_STAGES-1] * div_quot[RDIV_STAGES-1];
  assign r2_sq = r2 * r2;
  assign half_r4 = r2_sq[32:17];

  always_ff @(posedge clk) begin
    r2     <= r_sq[32:16];
    sq_seg <= div_seg[RDIV_STAGES-1];
    unique case (sq_seg)
      SEG_ZERO: memb <= '0;
      SEG_ONE:  memb <= MEMB_ONE;
      SEG_RISE: memb <= {1'b0, half_r4};
      SEG_FALL: memb <= MEMB_ONE - {1'b0, half_r4};
      default:  memb <= '0;
    endcase
  end

endmodule
`default_nettype wire

FILE: design/fie_merge.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// fie_merge
// Combine lane memberships: rule weights, weighted sum, and a pipelined
// divider with saturation to a signed Q8.8 result.
// -----------------------------------------------------------------------------
module fie_merge (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  input  fie_pkg::memb_arr_t         memb,
  input  fie_pkg::cons_arr_t         cons,
  output logic                       out_valid,
  output logic signed [15:0]         result
);
  import fie_pkg::*;

  logic [MERGE_LAT-1:0] vld;

  memb_t              w    [COMBOS];
  logic signed [33:0] prod [COMBOS];
  logic [19:0]        den2;
  logic signed [36:0] num;
  logic [19:0]        den3;

  logic [35:0] mag_c;
  logic        neg4;
  logic        ovf4;
  logic [19:0] den4;
  logic [19:0] rem4;
  logic [15:0] low4;

  logic        qd_neg  [QDIV_STAGES];
  logic        qd_ovf  [QDIV_STAGES];
  logic [19:0] qd_den  [QDIV_STAGES];
  logic [19:0] qd_rem  [QDIV_STAGES];
  logic [15:0] qd_low  [QDIV_STAGES];
  logic [15:0] qd_quot [QDIV_STAGES];

  logic [19:0]        den_c;
  logic signed [36:0] num_c;
  logic [15:0]        q_fin;

  // Advance the valid marks
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[MERGE_LAT-2:0], in_valid};
    end
  end
  assign out_valid = vld[MERGE_LAT-1];

  // Rule weights: minimum of the selected memberships
  always_ff @(posedge clk) begin
    for (int c = 0; c < COMBOS; c++) begin
      memb_t wmin;
      memb_t m;
      wmin = MEMB_ONE;
      for (int i = 0; i < INPUT_COUNT; i++) begin
        m = ((c >> i) & 1) != 0 ? memb[i] : MEMB_ONE - memb[i];
        if (m < wmin) wmin = m;
      end
      w[c] <= wmin;
    end
  end

  // Products and weight sum
  always_comb begin
    den_c = '0;
    for (int c = 0; c < COMBOS; c++) den_c = den_c + 20'(w[c]);
  end
  always_ff @(posedge clk) begin
    for (int c = 0; c < COMBOS; c++) begin
      prod[c] <= 34'($signed({1'b0, w[c]}) * cons[c]);
    end
    den2 <= den_c;
  end

  // Sum the products
  always_comb begin
    num_c = '0;
    for (int c = 0; c < COMBOS; c++) num_c = num_c + 37'(prod[c]);
  end
  always_ff @(posedge clk) begin
    num  <= num_c;
    den3 <= den2;
  end

  // Magnitude, sign and overflow check
  assign mag_c = num[36] ? 36'(-num) : num[35:0];
  always_ff @(posedge clk) begin
    neg4 <= num[36];
    ovf4 <= mag_c >= {den3, 16'h0000};
    den4 <= den3;
    rem4 <= mag_c[35:16];
    low4 <= mag_c[15:0];
  end

  // Restoring divider, one quotient bit per stage
  for (genvar j = 0; j < QDIV_STAGES; j++) begin : g_qd
    logic [20:0] trial;
    logic        ge;
    logic        neg_in;
    logic        ovf_in;
    logic [19:0] den_in;
    logic [19:0] rem_in;
    logic [15:0] low_in;
    logic [15:0] quot_in;
    if (j == 0) begin : g_first
      assign neg_in  = neg4;
      assign ovf_in  = ovf4;
      assign den_in  = den4;
      assign rem_in  = rem4;
      assign low_in  = low4;
      assign quot_in = '0;
    end else begin : g_rest
      assign neg_in  = qd_neg[j-1];
      assign ovf_in  = qd_ovf[j-1];
      assign den_in  = qd_den[j-1];
      assign rem_in  = qd_rem[j-1];
      assign low_in  = qd_low[j-1];
      assign quot_in = qd_quot[j-1];
    end
    assign trial = {rem_in, low_in[15]};
    assign ge    = trial >= {1'b0, den_in};
    always_ff @(posedge clk) begin
      qd_neg[j]  <= neg_in;
      qd_ovf[j]  <= ovf_in;
      qd_den[j]  <= den_in;
      qd_rem[j]  <= ge ? 20'(trial - {1'b0, den_in}) : trial[19:0];
      qd_low[j]  <= {low_in[14:0], 1'b0};
      qd_quot[j] <= {quot_in[14:0], ge};
    end
  end

  // Apply sign and saturate
  assign q_fin = qd_quot[QDIV_STAGES-1];
  always_ff @(posedge clk) begin
    if (qd_ovf[QDIV_STAGES-1]) begin
      result <= qd_neg[QDIV_STAGES-1] ? -16'sd32768 : 16'sd32767;
    end else if (qd_neg[QDIV_STAGES-1]) begin
      result <= (q_fin > 16'h8000) ? -16'sd32768 : $signed(16'(-q_fin));
    end else begin
      result <= (q_fin > 16'h7fff) ? 16'sd32767 : $signed(q_fin);
    end
  end

endmodule
`default_nettype wire

FILE: design/fuzzy_inference_three_input.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// fuzzy_inference_three_input
// Three-input Sugeno fuzzy inference with quartic S-curve memberships.
// -----------------------------------------------------------------------------
// Usage:
//   Items enter on start while busy is low: three signed Q8.8 values and
//   three unsigned Q7.8 knees. busy is low at all times except during reset
//   and the cycle after it, so a new item may enter every cycle.
//   Each item yields one result on control_output, marked by done for one
//   cycle. The receiver cannot stall; results leave in order.
//   Each item passes the three membership lanes (segment select, then the
//   ratio divider, one bit per stage, then squaring) and then the merge
//   stage (rule weights and sums, then the output divider, one bit per
//   stage, then saturation).
//   The eight consequent registers are written through cfg_valid/cfg_ready
//   with cfg_index 0..7 and cfg_data; other indexes are ignored. cfg_ready
//   is always high. Write them only while no item is in flight.
//   Reset clears the consequents to zero and drops all items in flight.
// -----------------------------------------------------------------------------
module fuzzy_inference_three_input (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic signed [15:0]          first_input,
  input  wire logic signed [15:0]          second_input,
  input  wire logic signed [15:0]          third_input,
  input  wire logic [14:0]                 first_knee,
  input  wire logic [14:0]                 second_knee,
  input  wire logic [14:0]                 third_knee,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [fie_pkg::IDX_W-1:0]   cfg_index,
  input  wire logic [15:0]                 cfg_data,
  output logic                             done,
  output logic signed [15:0]               control_output
);
  import fie_pkg::*;

  cons_arr_t           consequent;
  logic [LANE_LAT-1:0] lane_vld;
  logic                accept;
  logic signed [15:0]  x_arr [INPUT_COUNT];
  logic [14:0]         k_arr [INPUT_COUNT];
  memb_arr_t           memb;

  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // Hold busy through reset
  always_ff @(posedge clk) begin
    busy <= rst;
  end

  // Consequent registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < COMBOS; c++) consequent[c] <= '0;
    end else if (cfg_valid && cfg_ready && cfg_index < IDX_W'(COMBOS)) begin
      consequent[cfg_index[INPUT_COUNT-1:0]] <= cfg_data;
    end
  end

  // Track items through the lanes
  always_ff @(posedge clk) begin
    if (rst) begin
      lane_vld <= '0;
    end else begin
      lane_vld <= {lane_vld[LANE_LAT-2:0], accept};
    end
  end

  assign x_arr[0] = first_input;
  assign x_arr[1] = second_input;
  assign x_arr[2] = third_input;
  assign k_arr[0] = first_knee;
  assign k_arr[1] = second_knee;
  assign k_arr[2] = third_knee;

  for (genvar i = 0; i < INPUT_COUNT; i++) begin : g_lane
    fie_lane u_lane (
      .clk  (clk),
      .x    (x_arr[i]),
      .knee (k_arr[i]),
      .memb (memb[i])
    );
  end

  fie_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (lane_vld[LANE_LAT-1]),
    .memb      (memb),
    .cons      (consequent),
    .out_valid (done),
    .result    (control_output)
  );

endmodule
`default_nettype wire

FILE: dv/tb_fuzzy_inference_three_input.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_fuzzy_inference_three_input
// Drives sensor vectors into the fuzzy inference pipeline and checks each
// control output against a bit-accurate predictor of memberships, rule
// weights and the saturated weighted average, over several consequent sets.
// -----------------------------------------------------------------------------
module tb_fuzzy_inference_three_input;
  import fie_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_WAIT = 60;
  localparam int N_RANDOM   = 1900;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [15:0] first_input = '0, second_input = '0, third_input = '0;
  logic [14:0] first_knee = '0, second_knee = '0, third_knee = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic done;
  logic signed [15:0] control_output;

  int sender_idle = 0;
  int idle_cycles = 0;

  fuzzy_inference_three_input i_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bit-accurate output predictor with its own consequent copy
  class inference_scoreboard;
    logic signed [15:0] rule_out [COMBOS];
    logic signed [15:0] pending [$];
    int errors = 0;

    function void set_rule(int idx, logic [15:0] val);
      if (idx < COMBOS) rule_out[idx] = val;
    endfunction

    function longint unsigned half_quartic(longint unsigned d, longint unsigned k);
      longint unsigned r, r2, r4;
      r  = (d << 16) / k;
      r2 = (r * r) >> 16;
      r4 = (r2 * r2) >> 16;
      return r4 >> 1;
    endfunction

    function longint unsigned grade(logic signed [15:0] x, logic [14:0] k);
      longint xs, ks;
      xs = x;
      ks = k;
      if (xs <= 0) return 0;
      if (ks == 0 || xs > 2 * ks) return 65536;
      if (xs <= ks) return half_quartic(xs, ks);
      return 65536 - half_quartic(2 * ks - xs, ks);
    endfunction

    function void note_item(logic signed [15:0] x0, x1, x2, logic [14:0] k0, k1, k2);
      longint unsigned g [INPUT_COUNT];
      longint unsigned w, m;
      longint num, den, q;
      g[0] = grade(x0, k0);
      g[1] = grade(x1, k1);
      g[2] = grade(x2, k2);
      num = 0;
      den = 0;
      for (int c = 0; c < COMBOS; c++) begin
        w = 65536;
        for (int i = 0; i < INPUT_COUNT; i++) begin
          m = c[i] ? g[i] : 65536 - g[i];
          if (m < w) w = m;
        end
        num += longint'(w) * longint'(rule_out[c]);
        den += longint'(w);
      end
      q = (den > 0) ? num / den : 0;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      pending.push_back(q[15:0]);
    endfunction

    function void check_result(logic signed [15:0] got);
      logic signed [15:0] want;
      if (pending.size() == 0) begin
        $error("control_output: unexpected result %0d", got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        $error("control_output: expected %0d, got %0d", want, got);
        errors++;
      end
    endfunction
  endclass

  inference_scoreboard sb = new();

  initial for (int i = 0; i < COMBOS; i++) sb.rule_out[i] = '0;

  // Check results and watch for a stuck pipeline
  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check_result(control_output);
      if (done || (start && !busy) || cfg_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT) begin
        $display("tb_fuzzy_inference_three_input: FAIL");
        $finish;
      end
    end
  end

  task automatic write_rule(int idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx[IDX_W-1:0];
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_rule(idx, val);
  endtask

  // Hold off until the pipeline is empty
  task automatic drain();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // Keep start high between back-to-back items; drop it only while idling
  task automatic send_item(logic [15:0] x0, x1, x2, logic [14:0] k0, k1, k2);
    while ($urandom_range(99) < sender_idle) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start        <= 1'b1;
    first_input  <= x0;
    second_input <= x1;
    third_input  <= x2;
    first_knee   <= k0;
    second_knee  <= k1;
    third_knee   <= k2;
    do @(posedge clk); while (busy);
    sb.note_item(x0, x1, x2, k0, k1, k2);
  endtask

  function automatic logic [15:0] rand_value();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(2048) - 256);
      2: return {$urandom_range(1) ? 8'hFF : 8'h00, 8'($urandom)};
      default: return 16'($urandom_range(32767));
    endcase
  endfunction

  function automatic logic [14:0] rand_knee();
    case ($urandom_range(3))
      0: return '0;
      1: return 15'($urandom);
      default: return 15'($urandom_range(1024));
    endcase
  endfunction

  task automatic send_random();
    logic [15:0] x0, x1, x2;
    logic [14:0] k0, k1, k2;
    k0 = rand_knee();
    k1 = rand_knee();
    k2 = rand_knee();
    // Mostly land inputs on the curve of their knee
    x0 = $urandom_range(3) != 0 ? 16'($urandom_range(2 * k0 + 1)) : rand_value();
    x1 = $urandom_range(3) != 0 ? 16'($urandom_range(2 * k1 + 1)) : rand_value();
    x2 = $urandom_range(3) != 0 ? 16'($urandom_range(2 * k2 + 1)) : rand_value();
    send_item(x0, x1, x2, k0, k1, k2);
  endtask

  task automatic load_rules(int mode);
    logic [15:0] v;
    for (int i = 0; i < COMBOS + 1; i++) begin
      case (mode)
        0: v = 16'h7FFF;
        1: v = 16'h8000;
        2: v = i[0] ? 16'h7FFF : 16'h8000;
        default: v = $urandom;
      endcase
      write_rule(i + (i == COMBOS ? 7 : 0), v);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int phase_idle [4] = '{0, 82, 0, 18};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: zero rules, then field extremes and zero knees
    send_item(16'h0000, 16'h0000, 16'h0000, 15'h0000, 15'h0000, 15'h0000);
    drain();
    load_rules(3);
    send_item(16'h7FFF, 16'h8000, 16'h0001, 15'h7FFF, 15'h7FFF, 15'h0000);
    send_item(16'h8000, 16'h7FFF, 16'hFFFF, 15'h0000, 15'h0001, 15'h7FFF);
    send_item(16'h7FFF, 16'h7FFF, 16'h7FFF, 15'h0000, 15'h0000, 15'h0000);
    send_item(16'h0100, 16'h0200, 16'h0080, 15'h0100, 15'h0100, 15'h0100);
    send_item(16'h0101, 16'h01FF, 16'h0001, 15'h0100, 15'h0100, 15'h0001);
    send_item(16'h0002, 16'h0003, 16'h0004, 15'h0001, 15'h0001, 15'h0001);
    send_item(16'h5555, 16'hAAAA, 16'h3FFF, 15'h2AAA, 15'h5555, 15'h1FFF);
    drain();
    for (int m = 0; m < 3; m++) begin
      load_rules(m);
      send_item(16'h0080, 16'h0180, 16'h0100, 15'h0100, 15'h0100, 15'h0100);
      send_item(16'h7FFF, 16'h0000, 16'h0050, 15'h0040, 15'h0040, 15'h0040);
      drain();
    end

    // Random phases, each with a fresh rule set
    for (int p = 0; p < 5; p++) begin
      load_rules(p == 4 ? 2 : 3);
      sender_idle = phase_idle[p % 4];
      for (int n = 0; n < N_RANDOM / 5; n++) send_random();
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb_fuzzy_inference_three_input: PASS");
    end else begin
      $display("tb_fuzzy_inference_three_input: FAIL");
    end
    $finish;
  end

endmodule
